@@ rtl/core/stream_pattern_mask_top_macros.svh @@
// ----------------------------------------------------------------------------
// stream_pattern_mask_top assertion macros
// Shared concurrent assertion forms, clocked on clk with active-low rst_n.
// ----------------------------------------------------------------------------
`ifndef STREAM_PATTERN_MASK_TOP_MACROS_SVH
`define STREAM_PATTERN_MASK_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also checks across reset.
`define SPM_ASSERT_RAW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/spm_pkg.sv @@
// ----------------------------------------------------------------------------
// spm_pkg
// Types and constants shared by the pattern mask blocks.
// ----------------------------------------------------------------------------
package spm_pkg;

  localparam int PATTERN_MAX  = 8;
  localparam int BYTE_W       = 8;
  localparam int CNT_W        = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W        = $clog2(PATTERN_MAX);
  localparam int LEN_W        = 4;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 64;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [BYTE_W-1:0]    MASK_BYTE = 8'd42;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN   = 4'd1;

  // One request's worth of output work: the first count bytes of data are
  // sent, bytes at or above mask_start go out as the mask byte.
  typedef struct packed {
    logic [PATTERN_MAX-1:0][BYTE_W-1:0] data;
    logic [CNT_W-1:0]                   count;
    logic [CNT_W-1:0]                   mask_start;
    logic                               eos;
  } spm_job_t;

endpackage

@@ rtl/core/spm_ifs.sv @@
// ----------------------------------------------------------------------------
// spm stream interfaces
// Valid/ready channels for input bytes, output bytes and register writes.
// ----------------------------------------------------------------------------
interface spm_in_if;
  import spm_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              end_of_stream;
  modport source (output valid, in_byte, end_of_stream, input ready);
  modport sink   (input valid, in_byte, end_of_stream, output ready);
endinterface

interface spm_out_if;
  import spm_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              run_last;
  logic              stream_done;
  modport source (output valid, out_byte, run_last, stream_done, input ready);
  modport sink   (input valid, out_byte, run_last, stream_done, output ready);
endinterface

interface spm_cfg_if;
  import spm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/spm_front.sv @@
// ----------------------------------------------------------------------------
// spm_front
// Holds the registers and the byte window and turns each byte-releasing request into a job.
// ----------------------------------------------------------------------------
module spm_front (
  input  logic              clk,
  input  logic              rst_n,
  spm_in_if.sink            in_if,
  spm_cfg_if.sink           cfg_if,
  input  logic              q_full,
  output logic              push,
  output spm_pkg::spm_job_t job
);
  import spm_pkg::*;

  logic [CFG_DATA_W-1:0]              pat_r;
  logic [LEN_W-1:0]                   len_r;
  logic [CNT_W-1:0]                   fill_r;
  logic [PATTERN_MAX-1:0][BYTE_W-1:0] win_r;

  logic [CNT_W-1:0]                   len_act, fill_c, n_c, e_c, k_c;
  logic [PATTERN_MAX-1:0][BYTE_W-1:0] w_c, sh_c, win_nxt;
  logic                               full_c, hit_c, accept;

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = !q_full;
  assign accept       = in_if.valid && in_if.ready;

  always_comb begin
    if (len_r == '0) begin
      len_act = CNT_W'(1);
    end else if (CNT_W'(len_r) > CNT_W'(PATTERN_MAX)) begin
      len_act = CNT_W'(PATTERN_MAX);
    end else begin
      len_act = CNT_W'(len_r);
    end
  end

  // Append the new byte, then work out how many bytes leave the window.
  always_comb begin
    logic [CNT_W-1:0] idx;
    idx    = '0;
    fill_c = (fill_r >= CNT_W'(PATTERN_MAX)) ? CNT_W'(PATTERN_MAX - 1) : fill_r;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      w_c[i] = (CNT_W'(i) == fill_c) ? in_if.in_byte : win_r[i];
    end
    n_c    = fill_c + CNT_W'(1);
    e_c    = (n_c > len_act) ? (n_c - len_act) : '0;
    full_c = (n_c >= len_act);
    for (int i = 0; i < PATTERN_MAX; i++) begin
      idx     = e_c + CNT_W'(i);
      sh_c[i] = w_c[idx[IDX_W-1:0]];
    end
    hit_c = full_c;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (CNT_W'(i) < len_act && sh_c[i] != pat_r[BYTE_W*i +: BYTE_W]) begin
        hit_c = 1'b0;
      end
    end
    priority if (in_if.end_of_stream) begin
      k_c = n_c;
    end else if (hit_c) begin
      k_c = n_c;
    end else if (full_c) begin
      k_c = e_c + CNT_W'(1);
    end else begin
      k_c = '0;
    end
    for (int i = 0; i < PATTERN_MAX; i++) begin
      idx        = CNT_W'(i) + k_c;
      win_nxt[i] = w_c[idx[IDX_W-1:0]];
    end
  end

  assign push           = accept && (k_c != '0);
  assign job.data       = w_c;
  assign job.count      = k_c;
  assign job.mask_start = hit_c ? e_c : CNT_W'(PATTERN_MAX);
  assign job.eos        = in_if.end_of_stream;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= '0;
      len_r  <= LEN_W'(1);
      fill_r <= '0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == CFG_PATTERN_BYTES) begin
          pat_r <= cfg_if.data;
        end else if (cfg_if.index == CFG_PATTERN_LEN) begin
          len_r <= cfg_if.data[LEN_W-1:0];
        end
      end
      if (accept) begin
        fill_r <= n_c - k_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

endmodule

@@ rtl/core/spm_job_fifo.sv @@
// ----------------------------------------------------------------------------
// spm_job_fifo
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module spm_job_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  spm_pkg::spm_job_t push_job,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output spm_pkg::spm_job_t head
);
  import spm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CT_W  = $clog2(QUEUE_DEPTH + 1);

  spm_job_t          slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_r, rd_r;
  logic [CT_W-1:0]   count_r;

  assign full      = (count_r == CT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_r];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_r <= bump(wr_r);
      end
      if (pop) begin
        rd_r <= bump(rd_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_job;
    end
  end

endmodule

@@ rtl/core/spm_back.sv @@
// ----------------------------------------------------------------------------
// spm_back
// Walks the head job one output byte per cycle while out_if is ready.
// ----------------------------------------------------------------------------
module spm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              not_empty,
  input  spm_pkg::spm_job_t head,
  output logic              pop,
  spm_out_if.source         out_if
);
  import spm_pkg::*;

  logic [IDX_W-1:0] pos_r;
  logic             last_c, taken;

  assign last_c = (CNT_W'(pos_r) + CNT_W'(1) == head.count);
  assign taken  = out_if.valid && out_if.ready;
  assign pop    = taken && last_c;

  assign out_if.valid       = not_empty;
  assign out_if.out_byte    = (CNT_W'(pos_r) >= head.mask_start) ? MASK_BYTE
                                                                 : head.data[pos_r];
  assign out_if.run_last    = last_c;
  assign out_if.stream_done = last_c && head.eos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (taken) begin
      pos_r <= last_c ? '0 : pos_r + IDX_W'(1);
    end
  end

endmodule

@@ rtl/core/stream_pattern_mask_top.sv @@
// ----------------------------------------------------------------------------
// stream_pattern_mask_top
// Copies a byte stream, masking non-overlapping set-pattern matches with '*'.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one byte per request with end_of_stream on the last byte of
//   a stream. out_if returns the stream byte by byte; run_last marks the last
//   byte caused by an input request and stream_done the final byte of the
//   stream. cfg_if writes pattern_bytes (index 0) and pattern_len (index 1)
//   and is always ready; write it only while the block is idle.
//   The job of a request that releases bytes enters the job queue when the
//   request is taken, and its first byte goes out once it heads the queue.
//   Throughput: one input request per cycle while each causes at most one
//   output byte and out_if is ready. A request releasing k bytes (a pattern
//   hit or a stream flush) ties up the single output port for all k bytes.
//   The front keeps the window and builds a job per request that releases
//   bytes; a two-entry job queue decouples it from the back, which sends the
//   bytes. When out_if stalls the queue fills and in_if.ready falls after two
//   pending jobs. Reset empties the window and the queue and sets the pattern
//   to zero with length one; the window store needs no clearing pass.
// ----------------------------------------------------------------------------
module stream_pattern_mask_top (
  input  logic      clk,
  input  logic      rst_n,
  spm_in_if.sink    in_if,
  spm_out_if.source out_if,
  spm_cfg_if.sink   cfg_if
);
  import spm_pkg::*;

  // Job handoff from the front to the queue.
  logic     push;
  spm_job_t push_job;

  // Queue status and head job seen by the back.
  logic     q_full, q_not_empty, pop;
  spm_job_t head;

  spm_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .cfg_if (cfg_if),
    .q_full (q_full),
    .push   (push),
    .job    (push_job)
  );

  spm_job_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  spm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .not_empty (q_not_empty),
    .head      (head),
    .pop       (pop),
    .out_if    (out_if)
  );

endmodule

@@ rtl/core/spm_checker.sv @@
// ----------------------------------------------------------------------------
// spm_checker
// Port-level checks on the pattern mask block, bound to its top level.
// ----------------------------------------------------------------------------
`include "stream_pattern_mask_top_macros.svh"

module spm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_run_last,
  input logic       out_stream_done
);

  `SPM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_run_last) && $stable(out_stream_done), "stalled output changed")
  `SPM_ASSERT_NOW(a_done_is_last, out_valid && out_stream_done, out_run_last, "stream end not on a request end")
  `SPM_ASSERT_NOW(a_stall_has_work, !in_ready, out_valid, "input stalled with no pending output")
  `SPM_ASSERT_RAW(a_reset_empty, !rst_n, !out_valid && in_ready, "block not empty after reset")

endmodule

bind stream_pattern_mask_top spm_checker u_spm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_byte        (out_if.out_byte),
  .out_run_last    (out_if.run_last),
  .out_stream_done (out_if.stream_done)
);
